### rtl/gvn_pkg.sv
// ---------------------------------------------------------------------------
// gvn_pkg: shared types and constants of the grid vertex normal block
// grid sizes, coordinate format, item kinds, status codes and table helpers
// ---------------------------------------------------------------------------
package gvn_pkg;

   // grid and coordinate format
   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int COORD_BITS  = 24;

   localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DIM_MAX = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int DIM_W   = ($clog2(DIM_MAX + 1) > 7) ? $clog2(DIM_MAX + 1) : 7;

   // arithmetic widths
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int MUL_W   = (DIFF_W > 31) ? DIFF_W : 31;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_RAW = 2 * DIFF_W + 4;
   localparam int SUM_W   = (SUM_RAW > 64) ? 64 : ((SUM_RAW < 32) ? 32 : SUM_RAW);
   localparam int NUM_W   = 47;
   localparam int WORD_W  = 3 * COORD_BITS;

   // port formats fixed by the interface
   localparam int IN_COORD_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int NORMAL_W   = 16;

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS    = 2'd1;

   // item kinds after classification
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_OFF   = 2'd2;

   // result status
   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_WRITE  = 2'd1;
   localparam logic [1:0] ST_OFF    = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [NORMAL_W-1:0]   normal_type;
   typedef logic [ADDR_W-1:0]            addr_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] column;
      logic [5:0] row;
      coord_type  x;
      coord_type  y;
      coord_type  z;
      logic [7:0] mask;
   } cmd_type;

   typedef struct packed {
      normal_type normal_x;
      normal_type normal_y;
      normal_type normal_z;
      logic [1:0] status;
   } rsp_type;

   // low COORD_BITS of the sign-extended input
   function automatic coord_type to_coord(input logic signed [IN_COORD_W-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      return w[COORD_BITS-1:0];
   endfunction

   function automatic addr_type node_addr(input logic [5:0] column, input logic [5:0] row);
      return addr_type'(addr_type'(row) * addr_type'(MAX_COLUMNS)) + addr_type'(column);
   endfunction

   // address step to neighbour k: east, ne, north, nw, west, sw, south, se
   function automatic addr_type nb_offset(input logic [2:0] k);
      int off;
      case (k)
         3'd0: off = 1;
         3'd1: off = 1 + MAX_COLUMNS;
         3'd2: off = MAX_COLUMNS;
         3'd3: off = MAX_COLUMNS - 1;
         3'd4: off = -1;
         3'd5: off = -1 - MAX_COLUMNS;
         3'd6: off = -MAX_COLUMNS;
         default: off = 1 - MAX_COLUMNS;
      endcase
      return addr_type'(off);
   endfunction

endpackage

### rtl/gvn_front.sv
// ---------------------------------------------------------------------------
// gvn_front: request intake and classification
// holds the grid size registers, sorts words into write, query or off grid,
// works out the neighbour mask and queues commands for the back end
// ---------------------------------------------------------------------------
module gvn_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_opcode,
   input  logic [5:0]                         req_column,
   input  logic [5:0]                         req_row,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_x,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_y,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_z,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gvn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gvn_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               cmd_pop,
   output logic                               cmd_empty,
   output gvn_pkg::cmd_type                   cmd_head
);

   logic [gvn_pkg::CSR_DATA_W-1:0] cols_ff, cols_in, rows_ff, rows_in;
   gvn_pkg::cmd_type               q_ff [2];
   gvn_pkg::cmd_type               q_in [2];
   logic                           wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]                     cnt_ff, cnt_in;

   logic [gvn_pkg::DIM_W-1:0] cols_eff, rows_eff, col_w, row_w;
   logic                      on_grid, east, west, north, south, push, pop;
   gvn_pkg::cmd_type          cmd;

   assign csr_ready = 1'b1;
   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_empty = (cnt_ff == 2'd0);
   assign cmd_head  = q_ff[rp_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && !cmd_empty;

   always_comb begin
      cols_eff = (gvn_pkg::DIM_W'(cols_ff) > gvn_pkg::DIM_W'(gvn_pkg::MAX_COLUMNS))
               ? gvn_pkg::DIM_W'(gvn_pkg::MAX_COLUMNS) : gvn_pkg::DIM_W'(cols_ff);
      rows_eff = (gvn_pkg::DIM_W'(rows_ff) > gvn_pkg::DIM_W'(gvn_pkg::MAX_ROWS))
               ? gvn_pkg::DIM_W'(gvn_pkg::MAX_ROWS) : gvn_pkg::DIM_W'(rows_ff);
      col_w    = gvn_pkg::DIM_W'(req_column);
      row_w    = gvn_pkg::DIM_W'(req_row);
      on_grid  = (col_w < cols_eff) && (row_w < rows_eff);
      east     = (col_w + 1'b1) < cols_eff;
      west     = (req_column != 6'd0);
      north    = (row_w + 1'b1) < rows_eff;
      south    = (req_row != 6'd0);

      cmd.column = req_column;
      cmd.row    = req_row;
      cmd.x      = gvn_pkg::to_coord(req_point_x);
      cmd.y      = gvn_pkg::to_coord(req_point_y);
      cmd.z      = gvn_pkg::to_coord(req_point_z);
      cmd.mask   = {east & south, south, west & south, west,
                    west & north, north, east & north, east};
      if (!on_grid) begin
         cmd.kind = gvn_pkg::KIND_OFF;
      end else if (req_opcode == gvn_pkg::OP_WRITE) begin
         cmd.kind = gvn_pkg::KIND_WRITE;
      end else begin
         cmd.kind = gvn_pkg::KIND_QUERY;
      end
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gvn_pkg::REG_COLUMNS: cols_in = csr_data;
            gvn_pkg::REG_ROWS:    rows_in = csr_data;
            default: ;
         endcase
      end
      q_in  = q_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) begin
         q_in[wp_ff] = cmd;
         wp_in       = !wp_ff;
      end
      if (pop) begin
         rp_in = !rp_ff;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cols_ff <= gvn_pkg::CSR_DATA_W'(64);
         rows_ff <= gvn_pkg::CSR_DATA_W'(64);
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/gvn_back.sv
// ---------------------------------------------------------------------------
// gvn_back: node store and normal engine
// executes queued commands: stores nodes, gathers neighbours, sums cross
// products on one shared multiplier, then normalises by root and division
// ---------------------------------------------------------------------------
module gvn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  gvn_pkg::cmd_type cmd_head,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output gvn_pkg::rsp_type rsp_word
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_READ    = 4'd1;
   localparam logic [3:0] S_CROSS   = 4'd2;
   localparam logic [3:0] S_DRAIN   = 4'd3;
   localparam logic [3:0] S_MAG     = 4'd4;
   localparam logic [3:0] S_NORM    = 4'd5;
   localparam logic [3:0] S_SQUARE  = 4'd6;
   localparam logic [3:0] S_ROOT    = 4'd7;
   localparam logic [3:0] S_DIVLOAD = 4'd8;
   localparam logic [3:0] S_DIVIDE  = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   localparam logic [1:0] DST_S2 = 2'd3;

   typedef logic signed [gvn_pkg::DIFF_W-1:0] diff_type;
   typedef logic signed [gvn_pkg::SUM_W-1:0]  sum_type;
   typedef logic [gvn_pkg::SUM_W-1:0]         mag_type;

   logic [gvn_pkg::WORD_W-1:0] mem [gvn_pkg::DEPTH];
   logic [gvn_pkg::WORD_W-1:0] rdata_ff, wd;
   gvn_pkg::addr_type          ra, wa;
   logic                       we;

   logic [3:0]                   state_ff, state_in;
   gvn_pkg::addr_type            base_ff, base_in;
   logic [3:0]                   rc_ff, rc_in, rdi_ff, rdi_in;
   logic                         rdv_ff, rdv_in;
   gvn_pkg::coord_type           o_ff [3];
   gvn_pkg::coord_type           o_in [3];
   diff_type                     d_ff [8][3];
   diff_type                     d_in [8][3];
   logic [7:0]                   pm_ff, pm_in;
   logic [2:0]                   cnt_ff, cnt_in, pc_ff, pc_in;
   logic signed [gvn_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                         pv_ff, pv_in, pneg_ff, pneg_in;
   logic [1:0]                   pdst_ff, pdst_in, comp_ff, comp_in;
   sum_type                      sum_ff [3];
   sum_type                      sum_in [3];
   logic                         neg_ff [3];
   logic                         neg_in [3];
   mag_type                      mag_ff [3];
   mag_type                      mag_in [3];
   logic [63:0]                  s2_ff, s2_in, rem_ff, rem_in, root_ff, root_in;
   logic [4:0]                   k_ff, k_in;
   logic [gvn_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [15:0]                  q_ff, q_in;
   gvn_pkg::normal_type          nrm_ff [3];
   gvn_pkg::normal_type          nrm_in [3];
   gvn_pkg::rsp_type             res_ff, res_in;

   logic signed [gvn_pkg::MUL_W-1:0] mul_a, mul_b;
   gvn_pkg::coord_type nb_c [3];
   diff_type           nd [3];
   sum_type            term;
   mag_type            orv;
   logic [63:0]        bitv, trial;
   logic [31:0]        len;
   logic [gvn_pkg::NUM_W-1:0] dv;
   logic [15:0]        qv;

   assign rsp_word = res_ff;
   assign prod_in  = mul_a * mul_b;
   assign len      = root_ff[31:0];

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      rc_in    = rc_ff;
      rdv_in   = 1'b0;
      rdi_in   = rdi_ff;
      o_in     = o_ff;
      d_in     = d_ff;
      pm_in    = pm_ff;
      cnt_in   = cnt_ff;
      pc_in    = pc_ff;
      pv_in    = 1'b0;
      pneg_in  = pneg_ff;
      pdst_in  = pdst_ff;
      comp_in  = comp_ff;
      sum_in   = sum_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      s2_in    = s2_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      k_in     = k_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      nrm_in   = nrm_ff;
      res_in   = res_ff;
      mul_a    = '0;
      mul_b    = '0;
      we       = 1'b0;
      wa       = gvn_pkg::node_addr(cmd_head.column, cmd_head.row);
      wd       = {cmd_head.z, cmd_head.y, cmd_head.x};
      ra       = base_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      bitv     = 64'(1) << {k_ff, 1'b0};
      trial    = root_ff + bitv;
      dv       = gvn_pkg::NUM_W'(len) << k_ff[3:0];
      qv       = '0;
      orv      = mag_ff[0] | mag_ff[1] | mag_ff[2];
      nb_c[0]  = rdata_ff[gvn_pkg::COORD_BITS-1:0];
      nb_c[1]  = rdata_ff[2*gvn_pkg::COORD_BITS-1:gvn_pkg::COORD_BITS];
      nb_c[2]  = rdata_ff[3*gvn_pkg::COORD_BITS-1:2*gvn_pkg::COORD_BITS];
      for (int c = 0; c < 3; c++) begin
         nd[c] = {nb_c[c][gvn_pkg::COORD_BITS-1], nb_c[c]}
               - {o_ff[c][gvn_pkg::COORD_BITS-1], o_ff[c]};
      end

      // product accumulation from the registered multiplier output
      term = gvn_pkg::SUM_W'(prod_ff);
      if (pv_ff) begin
         if (pdst_ff == DST_S2) begin
            s2_in = s2_ff + 64'($unsigned(prod_ff));
         end else if (pneg_ff) begin
            sum_in[pdst_ff] = sum_ff[pdst_ff] - term;
         end else begin
            sum_in[pdst_ff] = sum_ff[pdst_ff] + term;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_head.kind)
                  gvn_pkg::KIND_WRITE: begin
                     we       = 1'b1;
                     res_in   = '{'0, '0, '0, gvn_pkg::ST_WRITE};
                     state_in = S_OUT;
                  end
                  gvn_pkg::KIND_QUERY: begin
                     base_in  = gvn_pkg::node_addr(cmd_head.column, cmd_head.row);
                     pm_in    = cmd_head.mask;
                     rc_in    = 4'd0;
                     sum_in   = '{'0, '0, '0};
                     s2_in    = '0;
                     state_in = S_READ;
                  end
                  default: begin
                     res_in   = '{'0, '0, '0, gvn_pkg::ST_OFF};
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_READ: begin
            // centre node first, then the eight neighbours
            if (rc_ff < 4'd9) begin
               if (rc_ff != 4'd0) begin
                  ra = base_ff + gvn_pkg::nb_offset(3'(rc_ff - 4'd1));
               end
               rdv_in = 1'b1;
               rdi_in = rc_ff;
               rc_in  = rc_ff + 4'd1;
            end
            if (rdv_ff) begin
               if (rdi_ff == 4'd0) begin
                  o_in = nb_c;
               end else begin
                  for (int i = 0; i < 7; i++) begin
                     d_in[i] = d_ff[i+1];
                  end
                  d_in[7] = nd;
               end
               if (rdi_ff == 4'd8) begin
                  cnt_in   = 3'd0;
                  pc_in    = 3'd0;
                  state_in = S_CROSS;
               end
            end
         end
         S_CROSS: begin
            // pair of d[0] and d[1], six products per pair
            pv_in = pm_ff[0] & pm_ff[1];
            case (cnt_ff)
               3'd0: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][1]); mul_b = gvn_pkg::MUL_W'(d_ff[1][2]);
                  pdst_in = 2'd0; pneg_in = 1'b0;
               end
               3'd1: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][2]); mul_b = gvn_pkg::MUL_W'(d_ff[1][1]);
                  pdst_in = 2'd0; pneg_in = 1'b1;
               end
               3'd2: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][2]); mul_b = gvn_pkg::MUL_W'(d_ff[1][0]);
                  pdst_in = 2'd1; pneg_in = 1'b0;
               end
               3'd3: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][0]); mul_b = gvn_pkg::MUL_W'(d_ff[1][2]);
                  pdst_in = 2'd1; pneg_in = 1'b1;
               end
               3'd4: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][0]); mul_b = gvn_pkg::MUL_W'(d_ff[1][1]);
                  pdst_in = 2'd2; pneg_in = 1'b0;
               end
               default: begin
                  mul_a = gvn_pkg::MUL_W'(d_ff[0][1]); mul_b = gvn_pkg::MUL_W'(d_ff[1][0]);
                  pdst_in = 2'd2; pneg_in = 1'b1;
               end
            endcase
            if (cnt_ff == 3'd5) begin
               cnt_in = 3'd0;
               for (int i = 0; i < 7; i++) begin
                  d_in[i] = d_ff[i+1];
               end
               d_in[7] = d_ff[0];
               pm_in   = {pm_ff[0], pm_ff[7:1]};
               pc_in   = pc_ff + 3'd1;
               if (pc_ff == 3'd7) begin
                  state_in = S_DRAIN;
               end
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_DRAIN: begin
            state_in = S_MAG;
         end
         S_MAG: begin
            for (int c = 0; c < 3; c++) begin
               neg_in[c] = sum_ff[c][gvn_pkg::SUM_W-1];
               mag_in[c] = sum_ff[c][gvn_pkg::SUM_W-1] ? mag_type'(-sum_ff[c])
                                                       : mag_type'(sum_ff[c]);
            end
            state_in = S_NORM;
         end
         S_NORM: begin
            // one bit a cycle until the largest magnitude has 30 bits
            if (orv == '0) begin
               res_in   = '{'0, '0, '0, gvn_pkg::ST_NORMAL};
               state_in = S_OUT;
            end else if (|orv[gvn_pkg::SUM_W-1:30]) begin
               for (int c = 0; c < 3; c++) begin
                  mag_in[c] = mag_ff[c] >> 1;
               end
            end else if (!orv[29]) begin
               for (int c = 0; c < 3; c++) begin
                  mag_in[c] = mag_ff[c] << 1;
               end
            end else begin
               cnt_in   = 3'd0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (cnt_ff < 3'd3) begin
               mul_a   = gvn_pkg::MUL_W'({1'b0, mag_ff[cnt_ff[1:0]][29:0]});
               mul_b   = mul_a;
               pv_in   = 1'b1;
               pdst_in = DST_S2;
               pneg_in = 1'b0;
               cnt_in  = cnt_ff + 3'd1;
            end else if (cnt_ff == 3'd3) begin
               cnt_in = cnt_ff + 3'd1;
            end else begin
               rem_in   = s2_ff;
               root_in  = '0;
               k_in     = 5'd31;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            k_in = k_ff - 5'd1;
            if (k_ff == 5'd0) begin
               comp_in  = 2'd0;
               state_in = S_DIVLOAD;
            end
         end
         S_DIVLOAD: begin
            num_in   = (gvn_pkg::NUM_W'(mag_ff[comp_ff][29:0]) << 14)
                     + gvn_pkg::NUM_W'(len >> 1);
            q_in     = '0;
            k_in     = 5'd15;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (num_ff >= dv) begin
               num_in = num_ff - dv;
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               q_in   = {q_ff[14:0], 1'b0};
            end
            k_in = k_ff - 5'd1;
            if (k_ff == 5'd0) begin
               qv = (q_in > 16'd16384) ? 16'd16384 : q_in;
               nrm_in[comp_ff] = neg_ff[comp_ff] ? -qv : qv;
               if (comp_ff == 2'd2) begin
                  res_in   = '{nrm_in[0], nrm_in[1], nrm_in[2], gvn_pkg::ST_NORMAL};
                  state_in = S_OUT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_DIVLOAD;
               end
            end
         end
         S_OUT: begin
            rsp_push = 1'b1;
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      rdi_ff  <= rdi_in;
      o_ff    <= o_in;
      d_ff    <= d_in;
      pm_ff   <= pm_in;
      cnt_ff  <= cnt_in;
      pc_ff   <= pc_in;
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      pdst_ff <= pdst_in;
      comp_ff <= comp_in;
      sum_ff  <= sum_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      s2_ff   <= s2_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      nrm_ff  <= nrm_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rc_ff    <= 4'd0;
         rdv_ff   <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rc_ff    <= rc_in;
         rdv_ff   <= rdv_in;
         pv_ff    <= pv_in;
      end
   end

endmodule

### rtl/gvn_rsp_queue.sv
// ---------------------------------------------------------------------------
// gvn_rsp_queue: result queue
// two-entry queue between the back end and the result ports
// ---------------------------------------------------------------------------
module gvn_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  gvn_pkg::rsp_type push_word,
   input  logic             pop,
   output logic             empty,
   output gvn_pkg::rsp_type head
);

   gvn_pkg::rsp_type q_ff [2];
   gvn_pkg::rsp_type q_in [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = q_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      q_in  = q_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_push) begin
         q_in[wp_ff] = push_word;
         wp_in       = !wp_ff;
      end
      if (do_pop) begin
         rp_in = !rp_ff;
      end
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/grid_vertex_normal.sv
// ---------------------------------------------------------------------------
// grid_vertex_normal: vertex normals over a grid of 3D nodes
// node positions in signed Q12.12, unit normals out in signed Q1.14
// ---------------------------------------------------------------------------
// Each request word either stores one node position (opcode 0) or asks for
// the normal at one node (opcode 1); every word gives exactly one result
// word, in request order. A node off the grid in use gives status 2 and a
// zero vector, a store gives status 1, a normal gives status 0. Nodes must be
// written before they are read: the node store has no reset and no clearing
// pass, so software loads the grid first. A query makes nine node reads from
// the node store, 48 cross-product terms on the one shared multiplier, one bit
// of normalising shift per cycle, a 32-step square root and three 16-step
// divisions; a zero sum of cross products skips the root and the divisions
// and gives a zero vector. The front end queues up to two words, so requests
// are taken while a query is running.
// The user must write the grid size registers (index 0 columns, index 1 rows)
// only while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module grid_vertex_normal (
   input  logic                                  clock,
   input  logic                                  reset,
   // request queue side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_opcode,
   input  logic [5:0]                            req_column,
   input  logic [5:0]                            req_row,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_x,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_y,
   input  logic signed [gvn_pkg::IN_COORD_W-1:0] req_point_z,
   // result queue side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [gvn_pkg::NORMAL_W-1:0]   rsp_normal_x,
   output logic signed [gvn_pkg::NORMAL_W-1:0]   rsp_normal_y,
   output logic signed [gvn_pkg::NORMAL_W-1:0]   rsp_normal_z,
   output logic [1:0]                            rsp_status,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gvn_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gvn_pkg::CSR_DATA_W-1:0]        csr_data
);

   // command queue between front and back
   gvn_pkg::cmd_type cmd_head;
   logic             cmd_pop, cmd_empty;

   // result path from back end into the result queue
   gvn_pkg::rsp_type back_word, rsp_head;
   logic             back_push, rsp_full;

   // intake, grid registers and classification
   gvn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_opcode  (req_opcode),
      .req_column  (req_column),
      .req_row     (req_row),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_pop     (cmd_pop),
      .cmd_empty   (cmd_empty),
      .cmd_head    (cmd_head)
   );

   // node store and normal engine
   gvn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp_word  (back_word)
   );

   // result words wait here for the consumer
   gvn_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .full      (rsp_full),
      .push_word (back_word),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_normal_x = rsp_head.normal_x;
   assign rsp_normal_y = rsp_head.normal_y;
   assign rsp_normal_z = rsp_head.normal_z;
   assign rsp_status   = rsp_head.status;

`ifndef NO_ASSERTIONS
   // stores and off-grid words carry a zero vector
   a_zero_vector : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != gvn_pkg::ST_NORMAL) |->
      (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("non-zero vector on a store or off-grid word");

   // normal components stay within the unit range
   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
      (rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384 &&
       rsp_normal_y >= -16'sd16384 && rsp_normal_y <= 16'sd16384 &&
       rsp_normal_z >= -16'sd16384 && rsp_normal_z <= 16'sd16384))
      else $error("normal component out of range");

   // out of reset the request queue is not full and the result queue is empty
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_full && rsp_empty))
      else $error("queue not empty after reset");
`endif

endmodule
